### rtl/mhpq_pkg.sv
// ============================================================================
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Holds the queue capacity, the command and status codes, and the records
// that pass between the cells of the sorted chain and the output buffer.
// ============================================================================
package mhpq_pkg;

  // Number of values the queue can hold; one cell per value.
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } cell_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                     load;
    logic                     extract;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  // One result item waiting in the output buffer.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
  } result_t;

endpackage

### rtl/max_heap_priority_queue.sv
// Throughput: one item per cycle while the result buffer has space, loads
// and extracts alike; every cell of the chain compares against the broadcast
// value in the same cycle, so no step walks the stored values. A two-entry
// result buffer absorbs consumer stalls. Reset (rst_n low at a clock edge)
// empties the queue at once; no clearing pass is needed since only the cell
// valid bits and buffer count are reset.
// ============================================================================
// max_heap_priority_queue: max-priority queue of signed 32-bit values
// The values live in a chain of cells kept sorted largest first, so the
// maximum is always in cell zero. A load ripples the new value into place,
// an extract shifts the whole chain toward cell zero.
// ============================================================================
module max_heap_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] command
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int N = mhpq_pkg::CAPACITY;

  mhpq_pkg::cell_t     cell_q [N];
  logic [N-1:0]        cell_gt;
  logic [N-1:0]        valid_vec;
  mhpq_pkg::cell_ctl_t ctl;
  mhpq_pkg::result_t   res;
  mhpq_pkg::result_t   out_res;
  logic                in_fire;
  logic                is_extract;
  logic                full;
  logic                empty;
  logic                buf_space;

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = buf_space;
  assign is_extract = (in_tuser[0] == mhpq_pkg::CMD_EXTRACT);

  // Valid cells always form a prefix, so the ends tell full and empty.
  assign full  = cell_q[N-1].valid;
  assign empty = !cell_q[0].valid;

  // A refused command leaves the chain untouched.
  assign ctl.load    = in_fire && !is_extract && !full;
  assign ctl.extract = in_fire && is_extract && !empty;
  assign ctl.value   = $signed(in_tdata);

  // The result is formed from the state before the item takes effect.
  always_comb begin
    res.value  = '0;
    res.status = mhpq_pkg::STATUS_OK;
    if (is_extract) begin
      if (empty) begin
        res.status = mhpq_pkg::STATUS_EMPTY;
      end else begin
        res.value = cell_q[0].data;
      end
    end else if (full) begin
      res.status = mhpq_pkg::STATUS_FULL;
    end
  end

  // Cell zero sees a left neighbor that always wins, so a value that beats
  // it lands there; the last cell sees an empty right neighbor.
  for (genvar i = 0; i < N; i++) begin : g_cell
    mhpq_pkg::cell_t left_in;
    mhpq_pkg::cell_t right_in;
    logic            left_gt_in;

    if (i == 0) begin : g_head
      assign left_in.valid = 1'b1;
      assign left_in.data  = '0;
      assign left_gt_in    = 1'b0;
    end else begin : g_body
      assign left_in    = cell_q[i-1];
      assign left_gt_in = cell_gt[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_in.valid = 1'b0;
      assign right_in.data  = '0;
    end else begin : g_next
      assign right_in = cell_q[i+1];
    end

    mhpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .left    (left_in),
      .left_gt (left_gt_in),
      .right   (right_in),
      .q       (cell_q[i]),
      .gt      (cell_gt[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  mhpq_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .space     (buf_space),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = out_res.status;

`ifndef SYNTHESIS
  // Occupied cells are contiguous from cell zero.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + {{(N-1){1'b0}}, 1'b1})) == '0)
    else $error("cell valid bits do not form a prefix");

  // The head of the chain holds the largest value.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cell_q[1].valid |-> (cell_q[0].data >= cell_q[1].data))
    else $error("chain head is smaller than its neighbor");

  // An accepted load into a non-full queue leaves it non-empty.
  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> cell_q[0].valid)
    else $error("load did not occupy the chain head");

  // Input back-pressure only happens while results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");
`endif

endmodule

### rtl/mhpq_cell.sv
// ============================================================================
// mhpq_cell: one slot of the sorted chain
// Holds one value. On a load it keeps its value, takes the new value, or
// takes its left neighbor's value; on an extract it takes its right
// neighbor's value, so the chain stays sorted largest first.
// ============================================================================
module mhpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mhpq_pkg::cell_ctl_t ctl,
  input  mhpq_pkg::cell_t    left,
  input  logic               left_gt,
  input  mhpq_pkg::cell_t    right,
  output mhpq_pkg::cell_t    q,
  output logic               gt
);

  logic                             valid_r, valid_nxt;
  logic signed [mhpq_pkg::DATA_W-1:0] data_r, data_nxt;

  // The new value belongs at or before this slot.
  assign gt = !valid_r || (ctl.value > data_r);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.extract) begin
      valid_nxt = right.valid;
      data_nxt  = right.data;
    end else if (ctl.load && gt) begin
      if (!left_gt) begin
        valid_nxt = 1'b1;
        data_nxt  = ctl.value;
      end else begin
        valid_nxt = left.valid;
        data_nxt  = left.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q.valid = valid_r;
  assign q.data  = data_r;

endmodule

### rtl/mhpq_outbuf.sv
// ============================================================================
// mhpq_outbuf: two-entry result buffer
// Decouples the result channel from the input side so an item can be taken
// while an earlier result still waits for the consumer.
// ============================================================================
module mhpq_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mhpq_pkg::result_t   push_data,
  output logic                space,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mhpq_pkg::result_t   pop_data
);

  logic [1:0]        cnt_r, cnt_nxt;
  mhpq_pkg::result_t slot0_r, slot0_nxt;
  mhpq_pkg::result_t slot1_r, slot1_nxt;
  logic              pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != 2'd0);
  assign space     = (cnt_r != 2'd2);
  assign pop_data  = slot0_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop && push) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = push_data;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_data;
      end
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

### tb/tb_max_heap_priority_queue.sv
// ============================================================================
// tb_max_heap_priority_queue: self-checking testbench of the max-heap queue
// A scoreboard keeps its own binary max-heap of the stored values and works
// out the result item of every accepted input item. Each result item is
// compared field by field with the oldest prediction. Stimulus is a short
// directed part followed by random phases that fill, drain and mix the
// queue. Random gaps are inserted on both channels, and one long consumer
// stall backs the block up until it stalls its input.
// ============================================================================
module tb_max_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  // Total number of items sent and length of each random phase.
  localparam int TOTAL_ITEMS  = 1750;
  localparam int PHASE_LEN    = 90;
  // Length of the one long consumer stall.
  localparam int HOLD_CYCLES  = 300;
  // Cycles to wait once nothing is outstanding.
  localparam int DRAIN_CYCLES = 20;
  // Hard stop for a hung run.
  localparam int CYCLE_LIMIT  = 1_000_000;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the heap as a binary max-heap and queues the result
  // item that each accepted input item should produce.
  // --------------------------------------------------------------------------
  class heap_scoreboard;
    logic signed [mhpq_pkg::DATA_W-1:0] heap_store [mhpq_pkg::CAPACITY];
    int                                 fill;
    bit                                 ordered;
    mhpq_pkg::result_t                  pending_results [$];
    int                                 errors;
    int                                 loads;
    int                                 extracts;
    int                                 full_refusals;
    int                                 empty_refusals;

    function new();
      foreach (heap_store[i]) heap_store[i] = '0;
      fill           = 0;
      ordered        = 1'b1;
      errors         = 0;
      loads          = 0;
      extracts       = 0;
      full_refusals  = 0;
      empty_refusals = 0;
    endfunction

    // Sift heap position pos (1-based) down within the first n positions.
    // The right child wins only when strictly larger, and a swap happens
    // only when the child is strictly larger than its parent.
    function void sift_down(int pos, int n);
      int                                 child;
      logic signed [mhpq_pkg::DATA_W-1:0] tmp;
      child = 2 * pos;
      while (child <= n) begin
        if (child + 1 <= n && heap_store[child] > heap_store[child-1])
          child = child + 1;
        if (heap_store[child-1] > heap_store[pos-1]) begin
          tmp                 = heap_store[pos-1];
          heap_store[pos-1]   = heap_store[child-1];
          heap_store[child-1] = tmp;
          pos                 = child;
          child               = 2 * pos;
        end else begin
          break;
        end
      end
    endfunction

    // Apply one command to the tracked heap and return its result item.
    function mhpq_pkg::result_t apply_command(mhpq_pkg::cmd_e cmd,
                                              logic signed [mhpq_pkg::DATA_W-1:0] value);
      mhpq_pkg::result_t res;
      res.value  = '0;
      res.status = mhpq_pkg::STATUS_OK;
      if (cmd == mhpq_pkg::CMD_LOAD) begin
        loads++;
        if (fill >= mhpq_pkg::CAPACITY) begin
          res.status = mhpq_pkg::STATUS_FULL;
          full_refusals++;
        end else begin
          heap_store[fill] = value;
          fill++;
          ordered = 1'b0;
        end
      end else begin
        extracts++;
        if (fill == 0) begin
          res.status = mhpq_pkg::STATUS_EMPTY;
          empty_refusals++;
        end else begin
          if (!ordered) begin
            for (int p = fill / 2; p >= 1; p--) sift_down(p, fill);
            ordered = 1'b1;
          end
          res.value     = heap_store[0];
          heap_store[0] = heap_store[fill-1];
          fill--;
          sift_down(1, fill);
        end
      end
      return res;
    endfunction

    function void take_item(mhpq_pkg::cmd_e cmd,
                            logic signed [mhpq_pkg::DATA_W-1:0] value);
      pending_results.push_back(apply_command(cmd, value));
    endfunction

    function void check_result(logic signed [mhpq_pkg::DATA_W-1:0] value,
                               logic [1:0] status_bits);
      mhpq_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $error("result item with nothing outstanding: result_value %0d, status %0d",
               value, status_bits);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
        $error("result_value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (status_bits !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status_bits);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] value
  logic [0:0]  in_tuser   = '0;   // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] result_value
  logic [1:0]  out_tuser;         // [1:0] status

  heap_scoreboard sb = new();

  int items_sent    = 0;
  int cycle_count   = 0;
  // Set by the stimulus to ask the consumer for one long stall; the consumer
  // clears it when the stall is over.
  bit hold_request  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  max_heap_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Random choices.
  // --------------------------------------------------------------------------

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Values: mostly full-range random, with a share of small values so that
  // ties are common, and a share of the signed extremes.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    int          k;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 90) begin
      k = $urandom_range(0, 6);
      return k - 3;
    end
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Producer side. The item is held on the bus until the block takes it;
  // valid is only lowered when a gap follows, so back-to-back items keep it
  // high without a second assignment in the same step.
  // --------------------------------------------------------------------------
  task automatic send_item(input mhpq_pkg::cmd_e cmd, input logic [31:0] value);
    int gap;
    gap       = pick_gap();
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_value(input logic [31:0] value);
    send_item(mhpq_pkg::CMD_LOAD, value);
  endtask

  task automatic extract_max();
    send_item(mhpq_pkg::CMD_EXTRACT, pick_value());
  endtask

  // --------------------------------------------------------------------------
  // Consumer side. Ready alternates between runs and stalls of random length.
  // When asked, it holds ready low for a long stretch while the producer keeps
  // offering items, so the result buffer fills and the input stalls.
  // --------------------------------------------------------------------------
  initial begin
    int run;
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        // A run that is never empty, sometimes a long one with no idling.
        run   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : pick_gap() + 1;
        stall = pick_gap();
        out_tready <= 1'b1;
        repeat (run) @(posedge clk);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Signals are read right at the rising edge, before the block's
  // own updates of that edge land, so each handshake is seen as it was when
  // the edge sampled it. An input item is recorded before a result item is
  // checked in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid === 1'b1 && in_tready === 1'b1)
        sb.take_item(mhpq_pkg::cmd_e'(in_tuser[0]), in_tdata);
      if (out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_result(out_tdata, out_tuser);
    end
  end

  // Watchdog: a run that hangs ends here as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, sb.pending_results.size());
    $display("tb_max_heap_priority_queue: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int             load_pct;
    mhpq_pkg::cmd_e cmd;

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An extract on the empty queue must be refused.
    extract_max();
    // The signed extremes and values around zero, including a tie.
    load_value(32'h7fff_ffff);
    load_value(32'h8000_0000);
    load_value(32'h0000_0000);
    load_value(32'hffff_ffff);
    load_value(32'd1);
    load_value(32'd5);
    load_value(32'd5);
    load_value(-32'sd5);
    // The first extract rebuilds the unordered heap.
    extract_max();
    extract_max();
    extract_max();
    // Loads after extracts leave the heap unordered again; equal values
    // must come out without disturbing the order.
    load_value(32'd7);
    load_value(32'd7);
    // Drain everything and run one extract past empty.
    repeat (8) extract_max();

    // Random part: phases that lean toward loads (reaching the full queue),
    // toward extracts (reaching the empty queue), and an even mix.
    for (int round = 0; items_sent < TOTAL_ITEMS; round++) begin
      case (round % 3)
        0:       load_pct = 85;
        1:       load_pct = 15;
        default: load_pct = 50;
      endcase
      // One long consumer stall while the queue is filling.
      if (round == 3) hold_request = 1'b1;
      for (int i = 0; i < PHASE_LEN && items_sent < TOTAL_ITEMS; i++) begin
        cmd = ($urandom_range(0, 99) < load_pct) ? mhpq_pkg::CMD_LOAD
                                                 : mhpq_pkg::CMD_EXTRACT;
        send_item(cmd, pick_value());
      end
    end
    in_tvalid <= 1'b0;

    // Wait for every outstanding result, then a few more cycles for strays.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads (%0d refused as full) and %0d extracts (%0d refused as empty)",
             sb.loads, sb.full_refusals, sb.extracts, sb.empty_refusals);
    $display("%0d items in %0d cycles, %0d mismatches", items_sent, cycle_count, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_max_heap_priority_queue: clean");
    end else begin
      $display("tb_max_heap_priority_queue: errors");
    end
    $finish;
  end

endmodule
